@@ sv/bmbe_pkg.sv @@
// ----------------------------------------------------------------------------
// bmbe_pkg
// shared types, constants and window helpers for the mask boundary extractor
// ----------------------------------------------------------------------------
package bmbe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT) + 1;
  localparam int REG_W = 11;
  localparam int OUT_W = 10;

  localparam logic [REG_W-1:0] WIDTH_MAX  = REG_W'(MAX_WIDTH);
  localparam logic [REG_W-1:0] HEIGHT_MAX = REG_W'(MAX_HEIGHT);

  // register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // window bit row*3+col, row 0 on top, col 0 on the left
  localparam logic [8:0] WIN_ALL    = 9'h1FF;
  localparam logic [8:0] WIN_KEEP   = 9'h0DB;
  localparam logic [8:0] COL_LEFT   = 9'h049;
  localparam logic [8:0] COL_RIGHT  = 9'h124;
  localparam logic [8:0] ROW_TOP    = 9'h007;
  localparam logic [8:0] ROW_BOTTOM = 9'h1C0;

  typedef struct packed {
    logic             last;
    logic             pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } pix_t;

  typedef struct packed {
    logic [OUT_W-1:0] col;
    logic [OUT_W-1:0] row;
    logic             on_boundary;
    logic             frame_last;
  } res_t;

  // shift the window one column left and put a new right column in
  function automatic logic [8:0] win_shift(input logic [8:0] w, input logic top,
                                           input logic mid, input logic bot);
    logic [8:0] s;
    s    = (w >> 1) & WIN_KEEP;
    s[2] = top;
    s[5] = mid;
    s[8] = bot;
    return s;
  endfunction

endpackage

@@ sv/bmbe_line_store.sv @@
// ----------------------------------------------------------------------------
// bmbe_line_store
// two one-bit line stores in one memory, one write and one registered read
// ----------------------------------------------------------------------------
module bmbe_line_store import bmbe_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [COL_W-1:0] waddr,
  input  logic [1:0]       wdata,
  input  logic             re,
  input  logic [COL_W-1:0] raddr,
  output logic [1:0]       rdata
);

  // bit 1 two rows back, bit 0 one row back
  logic [1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/bmbe_window.sv @@
// ----------------------------------------------------------------------------
// bmbe_window
// 3x3 window register, edge masking and boundary decision
// ----------------------------------------------------------------------------
module bmbe_window import bmbe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  logic             advance,
  input  pix_t             item,
  input  logic [1:0]       line,
  input  logic [REG_W-1:0] frame_width,
  input  logic [REG_W-1:0] frame_height,
  output res_t             res,
  output logic             res_valid,
  output logic [1:0]       line_wr
);

  logic [8:0]       win;
  logic [8:0]       post;
  logic [8:0]       eval;
  logic [REG_W-1:0] ccol;
  logic [ROW_W-1:0] crow;
  logic             up;
  logic             lo;

  assign up      = line[1];
  assign lo      = line[0];
  assign post    = win_shift(win, up, lo, item.pix);
  assign line_wr = {lo, item.pix};

  // warm once the window reaches the second row
  assign res_valid = (item.row >= ROW_W'(2)) ||
                     ((item.row == ROW_W'(1)) && (item.col != '0));

  always_comb begin
    if (item.col == '0) begin
      eval = win_shift(win, 1'b1, 1'b1, 1'b1);
      ccol = frame_width - REG_W'(1);
      crow = item.row - ROW_W'(2);
    end else begin
      eval = post;
      ccol = REG_W'(item.col) - REG_W'(1);
      crow = item.row - ROW_W'(1);
    end
    if (ccol == '0)                       eval = eval | COL_LEFT;
    if (ccol == frame_width - REG_W'(1))  eval = eval | COL_RIGHT;
    if (crow == '0)                       eval = eval | ROW_TOP;
    if (crow >= frame_height - REG_W'(1)) eval = eval | ROW_BOTTOM;
  end

  always_comb begin
    res.col         = ccol[OUT_W-1:0];
    res.row         = crow[OUT_W-1:0];
    res.on_boundary = eval[4] && (eval != WIN_ALL);
    res.frame_last  = item.last;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      win <= WIN_ALL;
    end else if (advance) begin
      win <= item.last ? WIN_ALL : post;
    end
  end

endmodule

@@ sv/binary_mask_boundary_extract_unit.sv @@
// ----------------------------------------------------------------------------
// binary_mask_boundary_extract_unit: result via evaluation stage and output register, W+1 items back
// throughput one transaction per cycle unless the output stalls, set by line store read-modify-write
// line store read at accept, written as the stage moves on, same-column reuse handled by forwarding
// reset: width and height 1024, frame position zero, window all ones, no line store clearing
// ----------------------------------------------------------------------------
module binary_mask_boundary_extract_unit import bmbe_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // configuration writes
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [REG_W-1:0] cfg_wdata,
  // input transactions
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             cmd,
  input  logic [7:0]       mask_byte,
  // result transactions
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] col,
  output logic [OUT_W-1:0] row,
  output logic             on_boundary,
  output logic             frame_last
);

  // configuration
  logic [REG_W-1:0] frame_width;
  logic [REG_W-1:0] frame_height;
  logic [REG_W-1:0] cfg_clamped;
  logic [REG_W-1:0] cfg_max;

  // position of the next incoming pixel
  logic [COL_W-1:0] pos_col;
  logic [ROW_W-1:0] pos_row;
  logic [COL_W-1:0] pos_col_next;
  logic [ROW_W-1:0] pos_row_next;
  logic [REG_W-1:0] col_inc;

  // evaluation stage
  logic             s1_valid;
  pix_t             s1_item;
  logic             s1_go;
  logic             in_accept;
  logic             acc_last;
  logic             pix_set;

  // line store and forwarding
  logic [1:0]       rdata;
  logic [1:0]       line;
  logic [1:0]       line_wr;
  logic             fwd;
  logic [1:0]       fwd_data;

  res_t             res;
  logic             res_valid;

  // --------------------------------------------------------------------------
  // configuration: clamp to the legal range, any write restarts the frame
  // --------------------------------------------------------------------------
  assign cfg_max = (cfg_index == REG_FRAME_WIDTH) ? WIDTH_MAX : HEIGHT_MAX;

  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_clamped = REG_W'(1);
    end else if (cfg_wdata > cfg_max) begin
      cfg_clamped = cfg_max;
    end else begin
      cfg_clamped = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_MAX;
      frame_height <= HEIGHT_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_clamped;
        REG_FRAME_HEIGHT: frame_height <= cfg_clamped;
        default:          frame_width  <= frame_width;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // input side: a flush transaction counts as a set pixel
  // the frame ends on the first column once the row is two below the image
  // --------------------------------------------------------------------------
  assign pix_set   = cmd || (mask_byte != 8'd0);
  assign s1_go     = s1_valid && (!res_valid || !out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_go;
  assign in_accept = in_valid && in_ready;
  assign acc_last  = (pos_col == '0) && (pos_row >= frame_height + REG_W'(1));
  assign col_inc   = REG_W'(pos_col) + REG_W'(1);

  always_comb begin
    if (acc_last) begin
      pos_col_next = '0;
      pos_row_next = '0;
    end else if (col_inc >= frame_width) begin
      pos_col_next = '0;
      pos_row_next = pos_row + ROW_W'(1);
    end else begin
      pos_col_next = col_inc[COL_W-1:0];
      pos_row_next = pos_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      pos_col <= '0;
      pos_row <= '0;
    end else if (in_accept) begin
      pos_col <= pos_col_next;
      pos_row <= pos_row_next;
    end
  end

  // --------------------------------------------------------------------------
  // evaluation stage holds the transaction while the line store read lands
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.last <= acc_last;
      s1_item.pix  <= pix_set;
      s1_item.col  <= pos_col;
      s1_item.row  <= pos_row;
    end
  end

  // write-back to the column being read in the same cycle is forwarded,
  // the memory returns the old value there (narrow frames, frame restart)
  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd      <= s1_go && (s1_item.col == pos_col);
      fwd_data <= line_wr;
    end
  end

  assign line = fwd ? fwd_data : rdata;

  bmbe_line_store u_line_store (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_item.col),
    .wdata (line_wr),
    .re    (in_accept),
    .raddr (pos_col),
    .rdata (rdata)
  );

  bmbe_window u_window (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg_we),
    .advance      (s1_go),
    .item         (s1_item),
    .line         (line),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .res          (res),
    .res_valid    (res_valid),
    .line_wr      (line_wr)
  );

  // --------------------------------------------------------------------------
  // output register, warm-up transactions leave no result
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      col         <= res.col;
      row         <= res.row;
      on_boundary <= res.on_boundary;
      frame_last  <= res.frame_last;
    end
  end

`ifndef SYNTHESIS
  // the column counter never leaves the configured width
  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    REG_W'(pos_col) < frame_width)
    else $error("column position beyond frame width");

  // an idle evaluation stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled with empty evaluation stage");

  // a stage that moves on without a new transaction ends empty
  a_stage_drains: assert property (@(posedge clk) disable iff (rst)
    (s1_go && !in_accept && !cfg_we) |=> !s1_valid)
    else $error("evaluation stage did not drain");

  // the closing transaction of a frame restarts the position
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && acc_last) |=> (pos_col == '0) && (pos_row == '0))
    else $error("position not restarted after frame end");
`endif

endmodule
